// ===== hdl/oisf_pkg.sv =====
// Shared types and constants for the oldest idle slot finder.
`timescale 1ns / 1ps

package oisf_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_FIND   = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  localparam int SLOT_W = 10;
  localparam int TIME_W = 32;
  localparam int RANGE_W = 11;

  // one table entry as held in the slot RAM
  typedef struct packed {
    logic              valid;
    logic              active;
    logic [TIME_W-1:0] stamp;
  } oisf_entry_t;

  // running best candidate of a find
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] stamp;
  } oisf_best_t;

endpackage

// ===== hdl/oisf_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module oisf_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/oisf_age_cmp.sv =====
// Shared age subtract and compare unit holding the best candidate of a find.
`timescale 1ns / 1ps

module oisf_age_cmp #(
  parameter int IW = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         step,
  input  logic [IW-1:0]                idx,
  input  oisf_pkg::oisf_entry_t        entry,
  input  logic [oisf_pkg::TIME_W-1:0]  now,
  input  logic [oisf_pkg::TIME_W-1:0]  min_idle,
  output oisf_pkg::oisf_best_t         best
);

  oisf_pkg::oisf_best_t        best_r;
  logic [oisf_pkg::TIME_W-1:0] best_age_r;
  logic [oisf_pkg::TIME_W-1:0] age;
  logic [oisf_pkg::TIME_W-1:0] thr;
  logic                        take;

  // best age already exceeds min_idle once a hit exists, so one compare serves both
  assign thr  = best_r.hit ? best_age_r : min_idle;
  assign age  = now - entry.stamp;
  assign take = step && entry.valid && !entry.active && (age > thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r     <= '0;
      best_age_r <= '0;
    end else if (clear) begin
      best_r     <= '0;
      best_age_r <= '0;
    end else if (take) begin
      best_r.hit   <= 1'b1;
      best_r.slot  <= idx[oisf_pkg::SLOT_W-1:0];
      best_r.stamp <= entry.stamp;
      best_age_r   <= age;
    end
  end

  assign best = best_r;

endmodule

// ===== hdl/oldest_idle_slot_finder_unit.sv =====
// Top level of the oldest idle slot finder: sequencer, slot RAM and age unit.
`timescale 1ns / 1ps

// Slot table searched for the valid, inactive slot that has been idle longest.
// Input channel in_*: in_tuser carries the command, in_tdata the operands.
// Result channel out_*: one word for find and read, none for insert and remove.
// Insert and remove write the slot RAM on acceptance; in_tready stays high behind them.
// Read fetches the slot through S_RDWAIT and S_RES into the output register.
// Find walks range_low .. range_high-1 (high saturated at NUM_SLOTS), one slot
// a cycle through the single RAM port and the shared age comparator; an empty
// range goes straight to the result word.
// After reset a clearing pass zeroes all NUM_SLOTS entries of the table; in_tready
// is low during it.
// The result sits in an output register; if the receiver stalls, a finished
// find or read waits for it before the next word is accepted.
// Not found returns found = 0 with all other result fields zero.
module oldest_idle_slot_finder_unit #(
  parameter int NUM_SLOTS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[9:0], entry_active[10], entry_time[42:11], range_low[53:43],
  // range_high[64:54], min_idle[96:65], now[128:97], zero[135:129]
  input  logic [135:0] in_tdata,
  // cmd[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // slot_out[9:0], out_active[10], out_time[42:11], zero[47:43]
  output logic [47:0]  out_tdata,
  // found[0]
  output logic [0:0]   out_tuser
);

  localparam int AW  = $clog2(NUM_SLOTS);
  localparam int SCW = (AW + 1 > oisf_pkg::RANGE_W) ? AW + 1 : oisf_pkg::RANGE_W;
  localparam int TW  = oisf_pkg::TIME_W;
  localparam int SW  = oisf_pkg::SLOT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_SCAN,
    S_RES
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [SCW-1:0]        n_r, n_nxt;
  logic [SCW-1:0]        idx_d_r, idx_d_nxt;
  logic [SCW-1:0]        hi_r, hi_nxt;
  logic [TW-1:0]         now_r, now_nxt;
  logic [TW-1:0]         min_idle_r, min_idle_nxt;
  logic [SW-1:0]         rd_slot_r, rd_slot_nxt;
  logic                  rd_intab_r, rd_intab_nxt;
  logic                  is_find_r, is_find_nxt;
  logic                  res_found_r, res_found_nxt;
  logic                  res_act_r, res_act_nxt;
  logic [TW-1:0]         res_time_r, res_time_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [47:0]           out_tdata_r, out_tdata_nxt;
  logic                  out_found_r, out_found_nxt;

  logic                  acc;
  logic [1:0]            cmd;
  logic [SW-1:0]         f_slot;
  logic                  f_act;
  logic [TW-1:0]         f_time;
  logic [SCW-1:0]        slot_ext;
  logic [SCW-1:0]        lo_ext;
  logic [SCW-1:0]        hi_ext;
  logic [SCW-1:0]        hi_sat;
  logic                  in_tab;

  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  oisf_pkg::oisf_entry_t ram_wdata;
  oisf_pkg::oisf_entry_t ram_rdata;

  logic                  cmp_clear;
  logic                  cmp_step;
  oisf_pkg::oisf_best_t  best;

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign f_slot    = in_tdata[9:0];
  assign f_act     = in_tdata[10];
  assign f_time    = in_tdata[42:11];
  assign slot_ext  = SCW'(in_tdata[9:0]);
  assign lo_ext    = SCW'(in_tdata[53:43]);
  assign hi_ext    = SCW'(in_tdata[64:54]);
  assign hi_sat    = (hi_ext > SCW'(NUM_SLOTS)) ? SCW'(NUM_SLOTS) : hi_ext;
  assign in_tab    = slot_ext < SCW'(NUM_SLOTS);

  oisf_ram #(
    .WIDTH ($bits(oisf_pkg::oisf_entry_t)),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  oisf_age_cmp #(
    .IW (SCW)
  ) u_age_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (cmp_clear),
    .step     (cmp_step),
    .idx      (idx_d_r),
    .entry    (ram_rdata),
    .now      (now_r),
    .min_idle (min_idle_r),
    .best     (best)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    n_nxt          = n_r;
    idx_d_nxt      = idx_d_r;
    hi_nxt         = hi_r;
    now_nxt        = now_r;
    min_idle_nxt   = min_idle_r;
    rd_slot_nxt    = rd_slot_r;
    rd_intab_nxt   = rd_intab_r;
    is_find_nxt    = is_find_r;
    res_found_nxt  = res_found_r;
    res_act_nxt    = res_act_r;
    res_time_nxt   = res_time_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_found_nxt  = out_found_r;
    ram_we         = 1'b0;
    ram_addr       = slot_ext[AW-1:0];
    ram_wdata      = '0;
    cmp_clear      = 1'b0;
    cmp_step       = 1'b0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          case (cmd)
            oisf_pkg::CMD_INSERT: begin
              ram_we           = in_tab;
              ram_wdata.valid  = 1'b1;
              ram_wdata.active = f_act;
              ram_wdata.stamp  = f_time;
            end
            oisf_pkg::CMD_REMOVE: begin
              ram_we = in_tab;
            end
            oisf_pkg::CMD_READ: begin
              rd_slot_nxt  = f_slot;
              rd_intab_nxt = in_tab;
              is_find_nxt  = 1'b0;
              state_nxt    = S_RDWAIT;
            end
            default: begin
              ram_addr     = lo_ext[AW-1:0];
              cmp_clear    = 1'b1;
              is_find_nxt  = 1'b1;
              now_nxt      = in_tdata[128:97];
              min_idle_nxt = in_tdata[96:65];
              if (lo_ext < hi_sat) begin
                idx_d_nxt = lo_ext;
                n_nxt     = lo_ext + SCW'(1);
                hi_nxt    = hi_sat;
                state_nxt = S_SCAN;
              end else begin
                state_nxt = S_RES;
              end
            end
          endcase
        end
      end
      S_RDWAIT: begin
        res_found_nxt = rd_intab_r && ram_rdata.valid;
        res_act_nxt   = ram_rdata.active;
        res_time_nxt  = ram_rdata.stamp;
        state_nxt     = S_RES;
      end
      S_SCAN: begin
        cmp_step = 1'b1;
        if (n_r != hi_r) begin
          ram_addr  = n_r[AW-1:0];
          idx_d_nxt = n_r;
          n_nxt     = n_r + SCW'(1);
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          if (is_find_r) begin
            out_found_nxt        = best.hit;
            out_tdata_nxt[9:0]   = best.hit ? best.slot : '0;
            out_tdata_nxt[42:11] = best.hit ? best.stamp : '0;
          end else begin
            out_found_nxt = res_found_r;
            if (res_found_r) begin
              out_tdata_nxt[9:0]   = rd_slot_r;
              out_tdata_nxt[10]    = res_act_r;
              out_tdata_nxt[42:11] = res_time_r;
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    n_r         <= n_nxt;
    idx_d_r     <= idx_d_nxt;
    hi_r        <= hi_nxt;
    now_r       <= now_nxt;
    min_idle_r  <= min_idle_nxt;
    rd_slot_r   <= rd_slot_nxt;
    rd_intab_r  <= rd_intab_nxt;
    is_find_r   <= is_find_nxt;
    res_found_r <= res_found_nxt;
    res_act_r   <= res_act_nxt;
    res_time_r  <= res_time_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_found_r;

endmodule

// ===== dv/tb_oldest_idle_slot_finder_unit.sv =====
// Self-checking bench for the oldest idle slot finder: directed and random commands vs a predictor.
`timescale 1ns / 1ps

module tb_oldest_idle_slot_finder_unit;

  localparam int TABLE_SLOTS   = 1024;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SETTLE_CYCLES = 48;
  localparam int REPORT_CAP    = 60;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic                        found;
    logic [oisf_pkg::SLOT_W-1:0] slot;
    logic                        active;
    logic [oisf_pkg::TIME_W-1:0] stamp;
  } slot_result_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata   = '0;
  logic [1:0]   in_tuser   = oisf_pkg::CMD_INSERT;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;

  oldest_idle_slot_finder_unit #(.NUM_SLOTS(TABLE_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predicted table contents
  bit                        slot_valid   [TABLE_SLOTS];
  bit                        slot_active  [TABLE_SLOTS];
  bit [oisf_pkg::TIME_W-1:0] slot_stamp   [TABLE_SLOTS];
  bit                        ever_written [TABLE_SLOTS];
  int                        written_slots[$];
  slot_result_t              pending_results[$];

  int cmd_count[4];
  int find_hits       = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int cycles          = 0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_len      = 0;
  int hold_seq      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int        win_base  = 0;
  int        win_size  = 2;
  int        win_items = 0;
  bit [31:0] tick_now;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when the test asks for one
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen  <= hold_seq;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("mismatch on %s in word %0d: got %h, want %h", field, results_checked,
               got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, out_tuser}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.found)
          report_mismatch("found", {31'd0, out_tuser[0]}, {31'd0, want.found});
        if (out_tdata[9:0] !== want.slot)
          report_mismatch("slot", {22'd0, out_tdata[9:0]}, {22'd0, want.slot});
        if (out_tdata[10] !== want.active)
          report_mismatch("active", {31'd0, out_tdata[10]}, {31'd0, want.active});
        if (out_tdata[42:11] !== want.stamp)
          report_mismatch("time", out_tdata[42:11], want.stamp);
        if (out_tdata[47:43] !== 5'd0)
          report_mismatch("padding", {27'd0, out_tdata[47:43]}, 32'd0);
      end
    end
  end

  // updates the predicted table; returns 1 when the command yields a result word
  function automatic bit predict_command(input logic [1:0] cmd, input logic [9:0] slot,
                                         input logic act, input logic [31:0] etime,
                                         input logic [10:0] lo, input logic [10:0] hi,
                                         input logic [31:0] min_idle,
                                         input logic [31:0] now,
                                         output slot_result_t res);
    int        top;
    bit [31:0] age;
    bit [31:0] best_age;
    res = '0;
    case (cmd)
      oisf_pkg::CMD_INSERT: begin
        slot_valid[slot]  = 1'b1;
        slot_active[slot] = act;
        slot_stamp[slot]  = etime;
        if (!ever_written[slot]) begin
          ever_written[slot] = 1'b1;
          written_slots.push_back(int'(slot));
        end
        return 1'b0;
      end
      oisf_pkg::CMD_REMOVE: begin
        slot_valid[slot]  = 1'b0;
        slot_active[slot] = 1'b0;
        slot_stamp[slot]  = '0;
        return 1'b0;
      end
      oisf_pkg::CMD_FIND: begin
        top      = (hi > TABLE_SLOTS) ? TABLE_SLOTS : int'(hi);
        best_age = '0;
        for (int n = int'(lo); n < top; n++) begin
          if (slot_valid[n] && !slot_active[n]) begin
            age = now - slot_stamp[n];
            if (age > min_idle && age > best_age) begin
              res.found = 1'b1;
              res.slot  = n[9:0];
              res.stamp = slot_stamp[n];
              best_age  = age;
            end
          end
        end
        if (res.found) find_hits++;
        return 1'b1;
      end
      default: begin
        if (slot_valid[slot]) begin
          res.found  = 1'b1;
          res.slot   = slot;
          res.active = slot_active[slot];
          res.stamp  = slot_stamp[slot];
        end
        return 1'b1;
      end
    endcase
  endfunction

  // presents one word and returns at the edge that accepts it, tvalid still high
  task automatic send_word(input logic [1:0] cmd, input logic [9:0] slot, input logic act,
                           input logic [31:0] etime, input logic [10:0] lo,
                           input logic [10:0] hi, input logic [31:0] min_idle,
                           input logic [31:0] now);
    slot_result_t want;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, now, min_idle, hi, lo, etime, act, slot};
    do @(posedge clk); while (!in_tready);
    if (predict_command(cmd, slot, act, etime, lo, hi, min_idle, now, want))
      pending_results.push_back(want);
    cmd_count[cmd]++;
  endtask

  task automatic sender_gap();
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 12) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // traffic clusters in a small slot window so that finds stay short
  task automatic send_random_command();
    logic [1:0]  cmd;
    logic [9:0]  slot;
    logic        act;
    logic [31:0] etime;
    logic [31:0] min_idle;
    logic [31:0] now;
    logic [10:0] lo;
    logic [10:0] hi;
    int          pick;
    if (win_items == 0) begin
      win_size  = $urandom_range(2, 40);
      win_items = 32;
      case ($urandom_range(0, 5))
        0:       win_base = 0;
        1:       win_base = TABLE_SLOTS - win_size;
        default: win_base = $urandom_range(0, TABLE_SLOTS - win_size);
      endcase
    end
    win_items--;
    tick_now += $urandom_range(0, 40);
    slot     = 10'($urandom);
    act      = 1'($urandom);
    etime    = $urandom;
    lo       = 11'($urandom_range(0, TABLE_SLOTS));
    hi       = 11'($urandom_range(0, TABLE_SLOTS));
    min_idle = $urandom;
    now      = $urandom;
    pick     = $urandom_range(0, 99);
    if (pick < 35) cmd = oisf_pkg::CMD_INSERT;
    else if (pick < 45) cmd = oisf_pkg::CMD_REMOVE;
    else if (pick < 80) cmd = oisf_pkg::CMD_FIND;
    else cmd = oisf_pkg::CMD_READ;
    case (cmd)
      oisf_pkg::CMD_INSERT: begin
        slot = 10'(win_base + $urandom_range(0, win_size - 1));
        act  = ($urandom_range(0, 9) < 3);
        case ($urandom_range(0, 5))
          0:       etime = $urandom;
          1:       etime = tick_now;
          default: etime = tick_now - 8 * $urandom_range(0, 64);
        endcase
      end
      oisf_pkg::CMD_REMOVE: begin
        slot = 10'(win_base + $urandom_range(0, win_size - 1));
      end
      oisf_pkg::CMD_FIND: begin
        case ($urandom_range(0, 9))
          0:       min_idle = '0;
          1:       min_idle = $urandom;
          2:       min_idle = '1;
          default: min_idle = $urandom_range(0, 400);
        endcase
        if ($urandom_range(0, 9) != 0) now = tick_now;
        pick = $urandom_range(0, 23);
        if (pick == 0) begin
          lo = 11'($urandom_range(0, 3));
          hi = 11'(TABLE_SLOTS);
        end else if (pick == 1) begin
          lo = 11'($urandom_range(0, TABLE_SLOTS));
          hi = 11'($urandom_range(0, lo));
        end else begin
          lo = 11'(win_base + $urandom_range(0, win_size / 3));
          hi = 11'(lo + $urandom_range(0, win_size + 4));
          if (hi > TABLE_SLOTS) hi = 11'(TABLE_SLOTS);
        end
      end
      default: begin
        // only slots that have been written at some point
        slot = 10'(win_base + $urandom_range(0, win_size - 1));
        for (int tries = 0; tries < 8 && !ever_written[slot]; tries++)
          slot = 10'(win_base + $urandom_range(0, win_size - 1));
        if (!ever_written[slot])
          slot = 10'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
      end
    endcase
    send_word(cmd, slot, act, etime, lo, hi, min_idle, now);
  endtask

  task automatic test_empty_table();
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd0, 11'd1024, 32'd0,
              32'h1234_5678);
  endtask

  task automatic test_table_extremes();
    send_word(oisf_pkg::CMD_INSERT, 10'd0, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_INSERT, 10'd1023, 1'b0, 32'hFFFF_FFFF, 11'd0, 11'd0, 32'd0,
              32'd0);
    send_word(oisf_pkg::CMD_INSERT, 10'd5, 1'b1, 32'd100, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_READ, 10'd0, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_READ, 10'd1023, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_READ, 10'd5, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    // slot 1023 has zero age here and must not qualify
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd0, 11'd1024, 32'd0,
              32'hFFFF_FFFF);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd0, 11'd1024, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd1023, 11'd1024, 32'd0, 32'd5);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd1024, 11'd1024, 32'd0, 32'd5);
  endtask

  task automatic test_ties_and_wrap();
    send_word(oisf_pkg::CMD_INSERT, 10'd7, 1'b0, 32'd50, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_INSERT, 10'd9, 1'b0, 32'd50, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd6, 11'd10, 32'd0, 32'd60);
    // stamp ahead of now wraps to a very large age
    send_word(oisf_pkg::CMD_INSERT, 10'd8, 1'b0, 32'd70, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd6, 11'd10, 32'd0, 32'd60);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd20, 11'd3, 32'd0, 32'd60);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd5, 11'd6, 32'd0, 32'd1000);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd9, 11'd10, 32'd0, 32'd50);
  endtask

  task automatic test_remove();
    send_word(oisf_pkg::CMD_REMOVE, 10'd0, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_READ, 10'd0, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd0, 11'd1, 32'd0, 32'hFFFF_FFFF);
    send_word(oisf_pkg::CMD_REMOVE, 10'd8, 1'b0, 32'd0, 11'd0, 11'd0, 32'd0, 32'd0);
    send_word(oisf_pkg::CMD_FIND, 10'd0, 1'b0, 32'd0, 11'd6, 11'd10, 32'd9, 32'd60);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len <= HOLD_CYCLES;
    hold_seq <= hold_seq + 1;
    repeat (12) send_random_command();
  endtask

  task automatic test_drain_pause();
    repeat (6) send_random_command();
    wait_drain();
    repeat (6) send_random_command();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (count) begin
      send_random_command();
      sender_gap();
    end
  endtask

  initial begin : stimulus
    tick_now = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_table_extremes();
    test_ties_and_wrap();
    test_remove();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(132, 0, 0);
    test_random_traffic(132, 67, 0);
    test_random_traffic(132, 0, 67);
    test_random_traffic(132, 35, 35);
    wait_drain();
    $display("covered %0d inserts, %0d removes, %0d finds (%0d hits), %0d reads",
             cmd_count[oisf_pkg::CMD_INSERT], cmd_count[oisf_pkg::CMD_REMOVE],
             cmd_count[oisf_pkg::CMD_FIND], find_hits, cmd_count[oisf_pkg::CMD_READ]);
    $display("%0d result words checked, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
